### hw/rtl/r2g_pkg.sv
// ----------------------------------------------------------------------------
// RGBA to gray package
// Widths, codes, reset values and the constant tables of the shades method.
// ----------------------------------------------------------------------------
package r2g_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned SUM_W       = 10;
  localparam int unsigned COEF_W      = 16;
  localparam int unsigned ARG_W       = 8;
  localparam int unsigned STEP_W      = 7;
  localparam int unsigned NUM_W       = 11;
  localparam int unsigned RECIP_SHIFT = 21;
  localparam int unsigned RECIP_W     = 19;
  localparam int unsigned LEVEL_W     = 9;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned TABLE_DEPTH = 2 ** ARG_W;

  localparam logic [PIX_W-1:0] SAT_MAX = 8'hFF;

  typedef enum logic [2:0] {
    MODE_AVERAGE,
    MODE_LUMINANCE,
    MODE_DESATURATE,
    MODE_MIN,
    MODE_MAX,
    MODE_SINGLE,
    MODE_SHADES
  } mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MODE,
    REG_AVG_RECIPROCAL,
    REG_COEF_RED,
    REG_COEF_GREEN,
    REG_COEF_BLUE,
    REG_MODE_ARGUMENT
  } reg_index_t;

  typedef enum logic [1:0] {
    CHAN_RED,
    CHAN_GREEN,
    CHAN_BLUE,
    CHAN_ALPHA
  } chan_t;

  localparam mode_t             RST_MODE           = MODE_AVERAGE;
  localparam logic [COEF_W-1:0] RST_AVG_RECIPROCAL = 16'd21846;
  localparam logic [COEF_W-1:0] RST_COEF_RED       = 16'd13933;
  localparam logic [COEF_W-1:0] RST_COEF_GREEN     = 16'd46871;
  localparam logic [COEF_W-1:0] RST_COEF_BLUE      = 16'd4732;
  localparam logic [ARG_W-1:0]  RST_MODE_ARGUMENT  = 8'd0;

  typedef logic [STEP_W-1:0]  step_table_t  [TABLE_DEPTH];
  typedef logic [RECIP_W-1:0] recip_table_t [TABLE_DEPTH];

  // Quotient of two constants by restoring shift and subtract.
  function automatic int unsigned const_quotient(int unsigned num, int unsigned den);
    int unsigned     q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      r = (r << 1) | 64'(num[b]);
      if (r >= 64'(den)) begin
        r = r - 64'(den);
        q = q | (32'd1 << b);
      end
    end
    return q;
  endfunction

  // Step size floor(255 / N), with N raised to two below two.
  function automatic step_table_t build_step_table();
    step_table_t t;
    int unsigned n;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      n = (i < 2) ? 2 : i;
      t[i] = STEP_W'(const_quotient(255, n));
    end
    return t;
  endfunction

  // Reciprocal of six steps, rounded up, exact for every numerator below 2**NUM_W.
  function automatic recip_table_t build_recip_table();
    recip_table_t t;
    int unsigned n;
    int unsigned d;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      n = (i < 2) ? 2 : i;
      d = 6 * const_quotient(255, n);
      t[i] = RECIP_W'(const_quotient(32'd1 << RECIP_SHIFT, d) + 1);
    end
    return t;
  endfunction

  localparam step_table_t  STEP_TABLE  = build_step_table();
  localparam recip_table_t RECIP_TABLE = build_recip_table();

endpackage

### hw/rtl/rgba_to_gray_multimode_top.sv
// ----------------------------------------------------------------------------
// RGBA to gray converter, four-stage pipeline.
// An accepted item passes stages 1 to 3 and the output register and shows on the
// result ports with done high.
// Throughput is one item per cycle; busy is always low.
// Reset clears the pipeline valid bits and restores the register defaults.
// ----------------------------------------------------------------------------
module rgba_to_gray_multimode_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [r2g_pkg::PIX_W-1:0]         red,
  input  logic [r2g_pkg::PIX_W-1:0]         green,
  input  logic [r2g_pkg::PIX_W-1:0]         blue,
  input  logic [r2g_pkg::PIX_W-1:0]         alpha,
  input  logic                              end_of_image,
  output logic                              done,
  output logic [r2g_pkg::PIX_W-1:0]         gray,
  output logic [r2g_pkg::PIX_W-1:0]         alpha_out,
  output logic                              end_of_image_out,
  input  logic                              cfg_write,
  input  logic [r2g_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [r2g_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned PW    = r2g_pkg::PIX_W;
  localparam int unsigned CW    = r2g_pkg::COEF_W;
  localparam int unsigned SW    = r2g_pkg::SUM_W;
  localparam int unsigned PRODW = PW + CW;
  localparam int unsigned AVGW  = SW + CW;
  localparam int unsigned LUMW  = PRODW + 2;
  localparam int unsigned SHW   = r2g_pkg::NUM_W + r2g_pkg::RECIP_W;
  localparam int unsigned QW    = r2g_pkg::LEVEL_W + r2g_pkg::STEP_W;

  // Configuration registers.
  r2g_pkg::mode_t              mode;
  logic [CW-1:0]               avg_reciprocal;
  logic [CW-1:0]               coef_red;
  logic [CW-1:0]               coef_green;
  logic [CW-1:0]               coef_blue;
  logic [r2g_pkg::ARG_W-1:0]   mode_argument;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= r2g_pkg::RST_MODE;
      avg_reciprocal <= r2g_pkg::RST_AVG_RECIPROCAL;
      coef_red       <= r2g_pkg::RST_COEF_RED;
      coef_green     <= r2g_pkg::RST_COEF_GREEN;
      coef_blue      <= r2g_pkg::RST_COEF_BLUE;
      mode_argument  <= r2g_pkg::RST_MODE_ARGUMENT;
    end else if (cfg_write) begin
      case (r2g_pkg::reg_index_t'(cfg_index))
        r2g_pkg::REG_MODE:           mode           <= r2g_pkg::mode_t'(cfg_data[2:0]);
        r2g_pkg::REG_AVG_RECIPROCAL: avg_reciprocal <= cfg_data[CW-1:0];
        r2g_pkg::REG_COEF_RED:       coef_red       <= cfg_data[CW-1:0];
        r2g_pkg::REG_COEF_GREEN:     coef_green     <= cfg_data[CW-1:0];
        r2g_pkg::REG_COEF_BLUE:      coef_blue      <= cfg_data[CW-1:0];
        r2g_pkg::REG_MODE_ARGUMENT:  mode_argument  <= cfg_data[r2g_pkg::ARG_W-1:0];
        default: ;
      endcase
    end
  end

  logic [r2g_pkg::STEP_W-1:0]  step;
  logic [r2g_pkg::RECIP_W-1:0] recip;

  assign step  = r2g_pkg::STEP_TABLE[mode_argument];
  assign recip = r2g_pkg::RECIP_TABLE[mode_argument];
  assign busy  = 1'b0;

  // Stage 1: sum, min, max, the shade numerator and the methods that need no multiplier.
  logic                         accept;
  logic [PW-1:0]                min_rg, max_rg, min_c, max_c;
  logic [SW-1:0]                sum;
  logic [PW-1:0]                simple_next;
  logic [PW:0]                  mid;
  logic [r2g_pkg::NUM_W-1:0]    num_next;

  assign accept = start && !busy;
  assign min_rg = (red < green) ? red : green;
  assign max_rg = (red > green) ? red : green;
  assign min_c  = (min_rg < blue) ? min_rg : blue;
  assign max_c  = (max_rg > blue) ? max_rg : blue;
  assign sum    = SW'(red) + SW'(green) + SW'(blue);
  assign mid    = (PW + 1)'(min_c) + (PW + 1)'(max_c);
  assign num_next = {1'b0, sum} + {1'b0, sum} + r2g_pkg::NUM_W'(step) * 2'd3;

  always_comb begin
    case (mode)
      r2g_pkg::MODE_DESATURATE: simple_next = mid[PW:1];
      r2g_pkg::MODE_MIN:        simple_next = min_c;
      r2g_pkg::MODE_MAX:        simple_next = max_c;
      r2g_pkg::MODE_SINGLE: begin
        case (r2g_pkg::chan_t'(mode_argument[1:0]))
          r2g_pkg::CHAN_RED:   simple_next = red;
          r2g_pkg::CHAN_GREEN: simple_next = green;
          r2g_pkg::CHAN_BLUE:  simple_next = blue;
          default:             simple_next = alpha;
        endcase
      end
      default:                  simple_next = '0;
    endcase
  end

  logic                      s1_valid;
  logic [PW-1:0]             s1_red, s1_green, s1_blue, s1_alpha, s1_simple;
  logic                      s1_eoi;
  logic [SW-1:0]             s1_sum;
  logic [r2g_pkg::NUM_W-1:0] s1_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_red    <= red;
    s1_green  <= green;
    s1_blue   <= blue;
    s1_alpha  <= alpha;
    s1_eoi    <= end_of_image;
    s1_sum    <= sum;
    s1_simple <= simple_next;
    s1_num    <= num_next;
  end

  // Stage 2: products.
  logic              s2_valid;
  logic [AVGW-1:0]   s2_avg_prod;
  logic [PRODW-1:0]  s2_prod_red, s2_prod_green, s2_prod_blue;
  logic [SHW-1:0]    s2_shade_prod;
  logic [PW-1:0]     s2_alpha, s2_simple;
  logic              s2_eoi;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_avg_prod   <= AVGW'(s1_sum) * AVGW'(avg_reciprocal);
    s2_prod_red   <= PRODW'(s1_red) * PRODW'(coef_red);
    s2_prod_green <= PRODW'(s1_green) * PRODW'(coef_green);
    s2_prod_blue  <= PRODW'(s1_blue) * PRODW'(coef_blue);
    s2_shade_prod <= SHW'(s1_num) * SHW'(recip);
    s2_alpha      <= s1_alpha;
    s2_simple     <= s1_simple;
    s2_eoi        <= s1_eoi;
  end

  // Stage 3: luminance sum, scaling, saturation and the shade level.
  logic [LUMW-1:0]  lum_sum;
  logic [SW-1:0]    avg_top;
  logic [LUMW-CW-1:0] lum_top;

  assign lum_sum = LUMW'(s2_prod_red) + LUMW'(s2_prod_green) + LUMW'(s2_prod_blue);
  assign avg_top = s2_avg_prod[AVGW-1:CW];
  assign lum_top = lum_sum[LUMW-1:CW];

  logic                        s3_valid;
  logic [PW-1:0]               s3_avg_gray, s3_lum_gray, s3_alpha, s3_simple;
  logic [r2g_pkg::LEVEL_W-1:0] s3_level;
  logic                        s3_eoi;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_avg_gray <= (avg_top > SW'(r2g_pkg::SAT_MAX)) ? r2g_pkg::SAT_MAX : avg_top[PW-1:0];
    s3_lum_gray <= (lum_top > (LUMW - CW)'(r2g_pkg::SAT_MAX)) ? r2g_pkg::SAT_MAX
                                                                 : lum_top[PW-1:0];
    s3_level    <= s2_shade_prod[SHW-1:r2g_pkg::RECIP_SHIFT];
    s3_alpha    <= s2_alpha;
    s3_simple   <= s2_simple;
    s3_eoi      <= s2_eoi;
  end

  // Stage 4: shade value, final selection and the output register.
  logic [QW-1:0] shade_val;
  logic [PW-1:0] shade_gray;
  logic [PW-1:0] gray_next;

  assign shade_val  = QW'(s3_level) * QW'(step);
  assign shade_gray = (shade_val > QW'(r2g_pkg::SAT_MAX)) ? r2g_pkg::SAT_MAX
                                                          : shade_val[PW-1:0];

  always_comb begin
    case (mode)
      r2g_pkg::MODE_AVERAGE:   gray_next = s3_avg_gray;
      r2g_pkg::MODE_LUMINANCE: gray_next = s3_lum_gray;
      r2g_pkg::MODE_SHADES:    gray_next = shade_gray;
      default:                 gray_next = s3_simple;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    gray             <= gray_next;
    alpha_out        <= s3_alpha;
    end_of_image_out <= s3_eoi;
  end

endmodule

### hw/rtl/r2g_checker.sv
// ----------------------------------------------------------------------------
// RGBA to gray port checker
// Checks pipeline timing and the pass-through fields at the top level ports.
// ----------------------------------------------------------------------------
module r2g_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic [r2g_pkg::PIX_W-1:0] alpha,
  input logic                      end_of_image,
  input logic                      done,
  input logic [r2g_pkg::PIX_W-1:0] alpha_out,
  input logic                      end_of_image_out
);

  // Every accepted item leaves with done high.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |-> ##4 done)
    else $error("accepted item produced no result");

  // No result appears without a matching accepted item.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(start && !busy, 4))
    else $error("result without a matching item");

  // Alpha travels with its item.
  assert property (@(posedge clk) disable iff (rst) done |-> alpha_out == $past(alpha, 4))
    else $error("alpha does not match its item");

  // The end-of-image mark travels with its item.
  assert property (@(posedge clk) disable iff (rst)
                   done |-> end_of_image_out == $past(end_of_image, 4))
    else $error("end-of-image mark does not match its item");

endmodule

bind rgba_to_gray_multimode_top r2g_checker u_r2g_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGBA to gray converter testbench
// A clocked driver feeds pixels from a queue with random gaps, and a clocked
// monitor checks every result against a converter model kept in step with
// the register writes. A short directed part covers each method, the
// unused mode, saturation and ignored register indexes. Random phases then
// change the registers and stream mixed pixels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned RANDOM_PHASES   = 14;
  localparam int unsigned ITEMS_PER_PHASE = 50;
  localparam int unsigned REPORT_LIMIT    = 10;

  localparam logic [2:0]                      MODE_UNUSED  = 3'd7;
  localparam logic [r2g_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [r2g_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [r2g_pkg::PIX_W-1:0] red;
    logic [r2g_pkg::PIX_W-1:0] green;
    logic [r2g_pkg::PIX_W-1:0] blue;
    logic [r2g_pkg::PIX_W-1:0] alpha;
    logic                      eoi;
  } pixel_t;

  typedef struct packed {
    logic [r2g_pkg::PIX_W-1:0] gray;
    logic [r2g_pkg::PIX_W-1:0] alpha;
    logic                      eoi;
  } gray_result_t;

  logic                            clk          = 1'b0;
  logic                            rst          = 1'b1;
  logic                            start        = 1'b0;
  logic                            busy;
  logic [r2g_pkg::PIX_W-1:0]       red          = '0;
  logic [r2g_pkg::PIX_W-1:0]       green        = '0;
  logic [r2g_pkg::PIX_W-1:0]       blue         = '0;
  logic [r2g_pkg::PIX_W-1:0]       alpha        = '0;
  logic                            end_of_image = 1'b0;
  logic                            done;
  logic [r2g_pkg::PIX_W-1:0]       gray;
  logic [r2g_pkg::PIX_W-1:0]       alpha_out;
  logic                            end_of_image_out;
  logic                            cfg_write    = 1'b0;
  logic [r2g_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [r2g_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;

  logic [2:0]                 conv_mode     = r2g_pkg::RST_MODE;
  logic [r2g_pkg::COEF_W-1:0] conv_recip    = r2g_pkg::RST_AVG_RECIPROCAL;
  logic [r2g_pkg::COEF_W-1:0] conv_coef_red = r2g_pkg::RST_COEF_RED;
  logic [r2g_pkg::COEF_W-1:0] conv_coef_grn = r2g_pkg::RST_COEF_GREEN;
  logic [r2g_pkg::COEF_W-1:0] conv_coef_blu = r2g_pkg::RST_COEF_BLUE;
  logic [r2g_pkg::ARG_W-1:0]  conv_arg      = r2g_pkg::RST_MODE_ARGUMENT;

  pixel_t       pending_pixels[$];
  gray_result_t expected_grays[$];
  int unsigned  fail_count  = 0;
  int unsigned  cycle_count = 0;
  int unsigned  gap_left    = 0;
  int unsigned  burst_left  = 0;

  rgba_to_gray_multimode_top uut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .red              (red),
    .green            (green),
    .blue             (blue),
    .alpha            (alpha),
    .end_of_image     (end_of_image),
    .done             (done),
    .gray             (gray),
    .alpha_out        (alpha_out),
    .end_of_image_out (end_of_image_out),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic gray_result_t convert_pixel(pixel_t p);
    gray_result_t    res;
    int unsigned     sum;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     n;
    int unsigned     step;
    longint unsigned acc;
    sum = 32'(p.red) + 32'(p.green) + 32'(p.blue);
    lo = 32'((p.red < p.green) ? p.red : p.green);
    lo = (lo < 32'(p.blue)) ? lo : 32'(p.blue);
    hi = 32'((p.red > p.green) ? p.red : p.green);
    hi = (hi > 32'(p.blue)) ? hi : 32'(p.blue);
    case (conv_mode)
      r2g_pkg::MODE_AVERAGE: begin
        acc = (64'(sum) * 64'(conv_recip)) >> 16;
      end
      r2g_pkg::MODE_LUMINANCE: begin
        acc = (64'(p.red) * 64'(conv_coef_red) + 64'(p.green) * 64'(conv_coef_grn)
               + 64'(p.blue) * 64'(conv_coef_blu)) >> 16;
      end
      r2g_pkg::MODE_DESATURATE: begin
        acc = 64'((lo + hi) >> 1);
      end
      r2g_pkg::MODE_MIN: begin
        acc = 64'(lo);
      end
      r2g_pkg::MODE_MAX: begin
        acc = 64'(hi);
      end
      r2g_pkg::MODE_SINGLE: begin
        case (r2g_pkg::chan_t'(conv_arg[1:0]))
          r2g_pkg::CHAN_RED:   acc = 64'(p.red);
          r2g_pkg::CHAN_GREEN: acc = 64'(p.green);
          r2g_pkg::CHAN_BLUE:  acc = 64'(p.blue);
          default:             acc = 64'(p.alpha);
        endcase
      end
      r2g_pkg::MODE_SHADES: begin
        n = (conv_arg < 2) ? 2 : 32'(conv_arg);
        step = 32'(r2g_pkg::SAT_MAX) / n;
        acc = 64'((2 * sum + 3 * step) / (6 * step)) * 64'(step);
      end
      default: begin
        acc = 64'd0;
      end
    endcase
    res.gray  = (acc > 64'(r2g_pkg::SAT_MAX)) ? r2g_pkg::SAT_MAX : acc[r2g_pkg::PIX_W-1:0];
    res.alpha = p.alpha;
    res.eoi   = p.eoi;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [r2g_pkg::PIX_W-1:0] pick_channel(int unsigned kind);
    case (kind)
      6:       return $urandom_range(1) ? r2g_pkg::SAT_MAX : '0;
      8:       return $urandom_range(1) ? r2g_pkg::PIX_W'($urandom_range(250, 255))
                                        : r2g_pkg::PIX_W'($urandom_range(0, 5));
      default: return r2g_pkg::PIX_W'($urandom);
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t      p;
    int unsigned kind;
    kind = $urandom_range(9);
    p.red   = pick_channel(kind);
    p.green = pick_channel(kind);
    p.blue  = pick_channel(kind);
    p.alpha = r2g_pkg::PIX_W'($urandom);
    p.eoi   = ($urandom_range(15) == 0);
    if (kind == 7) begin
      p.green = p.red;
      p.blue  = p.red;
    end else if (kind == 9) begin
      p.blue = p.green;
    end
    return p;
  endfunction

  function automatic logic [r2g_pkg::CFG_DATA_W-1:0] pick_coef();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return r2g_pkg::CFG_DATA_W'($urandom);
    endcase
  endfunction

  task automatic flag_failure(string what);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  task automatic write_reg(logic [r2g_pkg::CFG_INDEX_W-1:0] idx,
                           logic [r2g_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      r2g_pkg::REG_MODE:           conv_mode     = value[2:0];
      r2g_pkg::REG_AVG_RECIPROCAL: conv_recip    = value;
      r2g_pkg::REG_COEF_RED:       conv_coef_red = value;
      r2g_pkg::REG_COEF_GREEN:     conv_coef_grn = value;
      r2g_pkg::REG_COEF_BLUE:      conv_coef_blu = value;
      r2g_pkg::REG_MODE_ARGUMENT:  conv_arg      = value[r2g_pkg::ARG_W-1:0];
      default:                     ;
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_pixels.size() != 0 || start || expected_grays.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // White with the end mark, then a mixed pixel with zero alpha.
  task automatic run_corner_pixels();
    pending_pixels.push_back('{red: 8'hFF, green: 8'hFF, blue: 8'hFF,
                               alpha: 8'hFF, eoi: 1'b1});
    pending_pixels.push_back('{red: 8'hC8, green: 8'h11, blue: 8'h60,
                               alpha: 8'h00, eoi: 1'b0});
    wait_idle();
  endtask

  // Driver: records each accepted item and presents the next one after a gap.
  always @(posedge clk) begin
    pixel_t p;
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        expected_grays.push_back(convert_pixel('{red: red, green: green, blue: blue,
                                                 alpha: alpha, eoi: end_of_image}));
      end
      if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        p = pending_pixels.pop_front();
        start        <= 1'b1;
        red          <= p.red;
        green        <= p.green;
        blue         <= p.blue;
        alpha        <= p.alpha;
        end_of_image <= p.eoi;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          gap_left = pick_gap();
          if ($urandom_range(39) == 0) burst_left = $urandom_range(20, 60);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    gray_result_t want;
    if (!rst && done) begin
      if (expected_grays.size() == 0) begin
        flag_failure($sformatf("unexpected result gray %0d alpha %0d eoi %0d",
                               gray, alpha_out, end_of_image_out));
      end else begin
        want = expected_grays.pop_front();
        if (gray !== want.gray) begin
          flag_failure($sformatf("gray: expected %0d, got %0d", want.gray, gray));
        end
        if (alpha_out !== want.alpha) begin
          flag_failure($sformatf("alpha_out: expected %0d, got %0d", want.alpha, alpha_out));
        end
        if (end_of_image_out !== want.eoi) begin
          flag_failure($sformatf("end_of_image_out: expected %0d, got %0d",
                                 want.eoi, end_of_image_out));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rgba_to_gray_multimode_top verification failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part, starting from the reset register values.
    pending_pixels.push_back('0);
    run_corner_pixels();
    write_reg(r2g_pkg::REG_MODE, r2g_pkg::CFG_DATA_W'(r2g_pkg::MODE_LUMINANCE));
    close_writes();
    run_corner_pixels();
    write_reg(r2g_pkg::REG_MODE, r2g_pkg::CFG_DATA_W'(r2g_pkg::MODE_DESATURATE));
    close_writes();
    run_corner_pixels();
    write_reg(r2g_pkg::REG_MODE, r2g_pkg::CFG_DATA_W'(r2g_pkg::MODE_MIN));
    close_writes();
    run_corner_pixels();
    write_reg(r2g_pkg::REG_MODE, r2g_pkg::CFG_DATA_W'(r2g_pkg::MODE_MAX));
    close_writes();
    run_corner_pixels();
    write_reg(r2g_pkg::REG_MODE, r2g_pkg::CFG_DATA_W'(r2g_pkg::MODE_SINGLE));
    write_reg(r2g_pkg::REG_MODE_ARGUMENT, r2g_pkg::CFG_DATA_W'(r2g_pkg::CHAN_ALPHA));
    close_writes();
    run_corner_pixels();
    write_reg(r2g_pkg::REG_MODE, r2g_pkg::CFG_DATA_W'(r2g_pkg::MODE_SHADES));
    write_reg(r2g_pkg::REG_MODE_ARGUMENT, '0);
    close_writes();
    run_corner_pixels();
    write_reg(r2g_pkg::REG_MODE, r2g_pkg::CFG_DATA_W'(MODE_UNUSED));
    close_writes();
    run_corner_pixels();
    write_reg(r2g_pkg::REG_MODE, r2g_pkg::CFG_DATA_W'(r2g_pkg::MODE_AVERAGE));
    write_reg(r2g_pkg::REG_AVG_RECIPROCAL, '1);
    close_writes();
    run_corner_pixels();
    write_reg(r2g_pkg::REG_AVG_RECIPROCAL, '0);
    close_writes();
    run_corner_pixels();
    write_reg(r2g_pkg::REG_MODE, r2g_pkg::CFG_DATA_W'(r2g_pkg::MODE_LUMINANCE));
    write_reg(r2g_pkg::REG_COEF_RED, '1);
    write_reg(r2g_pkg::REG_COEF_GREEN, '1);
    write_reg(r2g_pkg::REG_COEF_BLUE, '1);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);
    close_writes();
    run_corner_pixels();

    // Random phases with new register settings.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0 || $urandom_range(1)) write_reg(r2g_pkg::REG_AVG_RECIPROCAL, pick_coef());
      if (ph == 0 || $urandom_range(1)) write_reg(r2g_pkg::REG_COEF_RED, pick_coef());
      if (ph == 0 || $urandom_range(1)) write_reg(r2g_pkg::REG_COEF_GREEN, pick_coef());
      if (ph == 0 || $urandom_range(1)) write_reg(r2g_pkg::REG_COEF_BLUE, pick_coef());
      if (ph == 0 || $urandom_range(1)) begin
        case ($urandom_range(4))
          0:       write_reg(r2g_pkg::REG_MODE_ARGUMENT,
                             {8'($urandom), 8'($urandom_range(0, 3))});
          1:       write_reg(r2g_pkg::REG_MODE_ARGUMENT,
                             {8'($urandom), 8'($urandom_range(252, 255))});
          default: write_reg(r2g_pkg::REG_MODE_ARGUMENT, r2g_pkg::CFG_DATA_W'($urandom));
        endcase
      end
      if ($urandom_range(3) == 0) begin
        write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                  r2g_pkg::CFG_DATA_W'($urandom));
      end
      write_reg(r2g_pkg::REG_MODE, {13'($urandom), 3'($urandom_range(0, 7))});
      close_writes();
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pending_pixels.push_back(random_pixel());
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_grays.size() != 0) begin
      flag_failure($sformatf("%0d results never arrived", expected_grays.size()));
    end
    if (fail_count == 0) begin
      $display("rgba_to_gray_multimode_top verification clean");
    end else begin
      $display("rgba_to_gray_multimode_top verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/r2g_pkg.sv
hw/rtl/rgba_to_gray_multimode_top.sv
hw/rtl/r2g_checker.sv
tb/tb_top.sv
